[design/bea_pkg.sv]
`default_nettype none
package bea_pkg;

	localparam int NUM_BUTTONS_DEF = 8;
	localparam int MASK_W = 8;
	localparam int TIME_W = 32;
	localparam int QUERY_W = 3;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_W-1:0] REPEAT_DELAY_RST = 16'd380;
	localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RST = 16'd110;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REPEAT_DELAY    = 1'b0,
		REG_REPEAT_INTERVAL = 1'b1
	} cfg_reg_t;

	// per-button findings handed to the merge stage
	typedef struct packed {
		logic              held;
		logic              edge_hit;
		logic              rep;
		logic [TIME_W-1:0] dur;
	} lane_res_t;

	typedef struct packed {
		logic [MASK_W-1:0] held_mask;
		logic [MASK_W-1:0] press_edges;
		logic [MASK_W-1:0] repeat_mask;
		logic [TIME_W-1:0] held_duration;
	} result_t;

endpackage
`default_nettype wire

[design/bea_lane.sv]
`default_nettype none
module bea_lane (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        accept,
	input  wire logic                        pressed,
	input  wire logic [bea_pkg::TIME_W-1:0]  time_ms,
	input  wire logic [bea_pkg::CFG_W-1:0]   repeat_delay,
	input  wire logic [bea_pkg::CFG_W-1:0]   repeat_interval,
	output bea_pkg::lane_res_t               res
);

	logic                        prev_q;
	logic [bea_pkg::TIME_W-1:0]  press_q;
	logic [bea_pkg::TIME_W-1:0]  due_q;
	logic [bea_pkg::TIME_W-1:0]  since_due;
	logic                        edge_hit;
	logic                        fire;

	assign edge_hit  = pressed & ~prev_q;
	// wrap-aware: due when (now - due) is non-negative as a signed value
	assign since_due = time_ms - due_q;
	assign fire      = pressed & prev_q & ~since_due[bea_pkg::TIME_W-1];

	always_comb begin
		res.held     = pressed;
		res.edge_hit = edge_hit;
		res.rep      = edge_hit | fire;
		// an edge restarts the hold, so its duration is zero
		res.dur      = (pressed && !edge_hit) ? (time_ms - press_q) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 1'b0;
		end else if (accept) begin
			prev_q <= pressed;
		end
	end

	// held buttons always pass through an edge first, so no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			if (edge_hit) begin
				press_q <= time_ms;
				due_q   <= time_ms + {{(bea_pkg::TIME_W-bea_pkg::CFG_W){1'b0}}, repeat_delay};
			end else if (fire) begin
				due_q   <= time_ms +
					{{(bea_pkg::TIME_W-bea_pkg::CFG_W){1'b0}}, repeat_interval};
			end
		end
	end

endmodule
`default_nettype wire

[design/bea_merge.sv]
`default_nettype none
module bea_merge #(
	parameter int NUM_BUTTONS = bea_pkg::NUM_BUTTONS_DEF
) (
	input  wire bea_pkg::lane_res_t           lanes [NUM_BUTTONS],
	input  wire logic [bea_pkg::QUERY_W-1:0]  query_button,
	output bea_pkg::result_t                  res
);

	always_comb begin
		res = '0;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			res.held_mask[i]   = lanes[i].held;
			res.press_edges[i] = lanes[i].edge_hit;
			res.repeat_mask[i] = lanes[i].rep;
			// query past the last lane matches nothing and reads zero
			if (query_button == bea_pkg::QUERY_W'(i)) begin
				res.held_duration = lanes[i].dur;
			end
		end
	end

endmodule
`default_nettype wire

[design/bea_out_buf.sv]
`default_nettype none
module bea_out_buf (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire bea_pkg::result_t in_res,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output bea_pkg::result_t      out_res
);

	logic             out_v_q;
	logic             skid_v_q;
	bea_pkg::result_t out_q;
	bea_pkg::result_t skid_q;
	logic             accept;
	logic             out_free;

	assign in_ready  = ~skid_v_q;
	assign accept    = in_valid & ~skid_v_q;
	assign out_free  = ~out_v_q | out_ready;
	assign out_valid = out_v_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q  <= accept;
			end
		end else if (accept) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_v_q ? skid_q : in_res;
		end else if (accept) begin
			skid_q <= in_res;
		end
	end

endmodule
`default_nettype wire

[design/button_edge_and_autorepeat.sv]
// Output: an accepted result is registered in out_q, or in skid_q while the output stalls.
// Throughput: one request per cycle while in_ready holds; every button lane updates in the
// accepting cycle and a two-entry output buffer keeps input open while one result waits.
// Reset: arst_n clears the prior mask, the output buffer and loads the repeat delay (380)
// and interval (110); no clearing pass, the block is ready right after reset.
`default_nettype none
module button_edge_and_autorepeat #(
	parameter int NUM_BUTTONS = bea_pkg::NUM_BUTTONS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [bea_pkg::MASK_W-1:0]    buttons_now,
	input  wire logic [bea_pkg::TIME_W-1:0]    time_ms,
	input  wire logic [bea_pkg::QUERY_W-1:0]   query_button,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [bea_pkg::MASK_W-1:0]         held_mask,
	output logic [bea_pkg::MASK_W-1:0]         press_edges,
	output logic [bea_pkg::MASK_W-1:0]         repeat_mask,
	output logic [bea_pkg::TIME_W-1:0]         held_duration,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [bea_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bea_pkg::CFG_W-1:0]     cfg_data
);

	logic [bea_pkg::CFG_W-1:0] repeat_delay_q;
	logic [bea_pkg::CFG_W-1:0] repeat_interval_q;
	logic                      accept;
	bea_pkg::lane_res_t        lanes [NUM_BUTTONS];
	bea_pkg::result_t          merged;
	bea_pkg::result_t          out_res;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_delay_q    <= bea_pkg::REPEAT_DELAY_RST;
			repeat_interval_q <= bea_pkg::REPEAT_INTERVAL_RST;
		end else if (cfg_valid) begin
			unique case (bea_pkg::cfg_reg_t'(cfg_index))
				bea_pkg::REG_REPEAT_DELAY:    repeat_delay_q    <= cfg_data;
				bea_pkg::REG_REPEAT_INTERVAL: repeat_interval_q <= cfg_data;
				default: ;
			endcase
		end
	end

	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
		bea_lane u_lane (
			.clk             (clk),
			.arst_n          (arst_n),
			.accept          (accept),
			.pressed         (buttons_now[i]),
			.time_ms         (time_ms),
			.repeat_delay    (repeat_delay_q),
			.repeat_interval (repeat_interval_q),
			.res             (lanes[i])
		);
	end

	bea_merge #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_merge (
		.lanes        (lanes),
		.query_button (query_button),
		.res          (merged)
	);

	bea_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_res    (merged),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign held_mask     = out_res.held_mask;
	assign press_edges   = out_res.press_edges;
	assign repeat_mask   = out_res.repeat_mask;
	assign held_duration = out_res.held_duration;

endmodule
`default_nettype wire

[dv/tb.sv]
`default_nettype none
module tb;

	localparam int NB = bea_pkg::NUM_BUTTONS_DEF;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [bea_pkg::MASK_W-1:0] buttons_now;
	logic [bea_pkg::TIME_W-1:0] time_ms;
	logic [bea_pkg::QUERY_W-1:0] query_button;
	logic out_valid;
	logic out_ready;
	logic [bea_pkg::MASK_W-1:0] held_mask;
	logic [bea_pkg::MASK_W-1:0] press_edges;
	logic [bea_pkg::MASK_W-1:0] repeat_mask;
	logic [bea_pkg::TIME_W-1:0] held_duration;
	logic cfg_valid;
	logic cfg_ready;
	logic [bea_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bea_pkg::CFG_W-1:0] cfg_data;

	button_edge_and_autorepeat u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.buttons_now(buttons_now),
		.time_ms(time_ms),
		.query_button(query_button),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.held_mask(held_mask),
		.press_edges(press_edges),
		.repeat_mask(repeat_mask),
		.held_duration(held_duration),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// typematic state mirrored on the bench side
	logic [bea_pkg::CFG_W-1:0] delay_ms;
	logic [bea_pkg::CFG_W-1:0] interval_ms;
	logic [bea_pkg::MASK_W-1:0] last_mask;
	logic [bea_pkg::TIME_W-1:0] pressed_at [NB];
	logic [bea_pkg::TIME_W-1:0] due_at [NB];

	bea_pkg::result_t pending_polls [$];
	int mismatch_cnt;
	int cycle_cnt;
	int snd_idle_pct;
	int rcv_idle_pct;
	bit rcv_hold;
	logic [bea_pkg::TIME_W-1:0] cur_time;
	logic [bea_pkg::MASK_W-1:0] cur_mask;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic bea_pkg::result_t predict_poll(logic [bea_pkg::MASK_W-1:0] mask,
			logic [bea_pkg::TIME_W-1:0] now, logic [bea_pkg::QUERY_W-1:0] q);
		bea_pkg::result_t r;
		logic [bea_pkg::MASK_W-1:0] edges;
		logic [bea_pkg::MASK_W-1:0] reps;
		logic [bea_pkg::TIME_W-1:0] since;
		edges = mask & ~last_mask;
		reps = edges;
		for (int i = 0; i < NB; i++) begin
			since = now - due_at[i];
			if (edges[i]) begin
				pressed_at[i] = now;
				due_at[i] = now + bea_pkg::TIME_W'(delay_ms);
			end else if (mask[i] && !since[bea_pkg::TIME_W-1]) begin
				reps[i] = 1'b1;
				due_at[i] = now + bea_pkg::TIME_W'(interval_ms);
			end
		end
		last_mask = mask;
		r.held_mask = mask;
		r.press_edges = edges;
		r.repeat_mask = reps;
		r.held_duration = mask[q] ? now - pressed_at[q] : '0;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [bea_pkg::TIME_W-1:0] got,
			input logic [bea_pkg::TIME_W-1:0] want);
		mismatch_cnt++;
		$display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_cnt);
	endtask

	always @(posedge clk) begin : check_results
		bea_pkg::result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_polls.size() == 0) begin
				report_mismatch("result with nothing pending",
					bea_pkg::TIME_W'(held_mask), '0);
			end else begin
				want = pending_polls.pop_front();
				if (held_mask !== want.held_mask)
					report_mismatch("held_mask", bea_pkg::TIME_W'(held_mask),
						bea_pkg::TIME_W'(want.held_mask));
				if (press_edges !== want.press_edges)
					report_mismatch("press_edges", bea_pkg::TIME_W'(press_edges),
						bea_pkg::TIME_W'(want.press_edges));
				if (repeat_mask !== want.repeat_mask)
					report_mismatch("repeat_mask", bea_pkg::TIME_W'(repeat_mask),
						bea_pkg::TIME_W'(want.repeat_mask));
				if (held_duration !== want.held_duration)
					report_mismatch("held_duration", held_duration, want.held_duration);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready <= !rcv_hold && ($urandom_range(99) >= rcv_idle_pct);
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_poll(input logic [bea_pkg::MASK_W-1:0] mask,
			input logic [bea_pkg::TIME_W-1:0] now, input logic [bea_pkg::QUERY_W-1:0] q);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		buttons_now <= mask;
		time_ms <= now;
		query_button <= q;
		do
			@(posedge clk);
		while (!in_ready);
		pending_polls.push_back(predict_poll(mask, now, q));
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_polls.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic set_reg(input bea_pkg::cfg_reg_t idx, input logic [bea_pkg::CFG_W-1:0] val);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == bea_pkg::REG_REPEAT_DELAY)
			delay_ms = val;
		else
			interval_ms = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// reset values: first repeat at 380, then every 110
	task automatic test_edges_and_repeats();
		logic [bea_pkg::TIME_W-1:0] t0;
		t0 = 32'h0000_1000;
		send_poll(8'hFF, t0, 3'd0);
		for (int q = 1; q < NB; q++)
			send_poll(8'hFF, t0 + 32'd370 + bea_pkg::TIME_W'(q), bea_pkg::QUERY_W'(q));
		send_poll(8'hFF, t0 + 32'd380, 3'd7);
		send_poll(8'hFF, t0 + 32'd489, 3'd2);
		send_poll(8'hFF, t0 + 32'd490, 3'd5);
		send_poll(8'h0F, t0 + 32'd500, 3'd7);
		send_poll(8'hF0, t0 + 32'd501, 3'd4);
		send_poll(8'hAA, t0 + 32'd502, 3'd1);
		send_poll(8'h55, t0 + 32'd503, 3'd0);
		send_poll(8'h00, t0 + 32'd504, 3'd3);
	endtask

	task automatic test_time_wrap();
		// time running backwards after a press
		send_poll(8'h01, 32'd5000, 3'd0);
		send_poll(8'h01, 32'd4000, 3'd0);
		// press just before the counter wraps, repeat due just after it
		send_poll(8'h80, 32'hFFFF_FF00, 3'd7);
		send_poll(8'h80, 32'h0000_0100, 3'd7);
		// due time exactly half the range away, both sides
		send_poll(8'h02, 32'd0, 3'd1);
		send_poll(8'h02, 32'd380 + 32'h7FFF_FFFF, 3'd1);
		send_poll(8'h02, 32'd380 + 32'h7FFF_FFFF + 32'd110 + 32'h8000_0000, 3'd1);
		send_poll(8'hFF, 32'hFFFF_FFFF, 3'd6);
		send_poll(8'h00, 32'hFFFF_FFFF, 3'd6);
	endtask

	task automatic test_zero_timing();
		set_reg(bea_pkg::REG_REPEAT_DELAY, 16'd0);
		set_reg(bea_pkg::REG_REPEAT_INTERVAL, 16'd0);
		send_poll(8'h3C, 32'd100, 3'd2);
		send_poll(8'h3C, 32'd100, 3'd3);
		send_poll(8'h3D, 32'd101, 3'd0);
		send_poll(8'h3D, 32'd101, 3'd5);
		send_poll(8'h00, 32'd102, 3'd5);
	endtask

	task automatic test_max_timing();
		set_reg(bea_pkg::REG_REPEAT_DELAY, 16'hFFFF);
		set_reg(bea_pkg::REG_REPEAT_INTERVAL, 16'hFFFF);
		send_poll(8'hC3, 32'h8000_0000, 3'd0);
		send_poll(8'hC3, 32'h8000_0000 + 32'd65534, 3'd1);
		send_poll(8'hC3, 32'h8000_0000 + 32'd65535, 3'd6);
		send_poll(8'hC3, 32'h8000_0000 + 32'd131069, 3'd7);
		send_poll(8'hC3, 32'h8000_0000 + 32'd131070, 3'd7);
		send_poll(8'h00, 32'h8000_0000 + 32'd131071, 3'd0);
	endtask

	task automatic test_random_polls(input int n, input int snd_pct, input int rcv_pct,
			input logic [bea_pkg::CFG_W-1:0] dly, input logic [bea_pkg::CFG_W-1:0] ivl);
		int span;
		int r;
		set_reg(bea_pkg::REG_REPEAT_DELAY, dly);
		set_reg(bea_pkg::REG_REPEAT_INTERVAL, ivl);
		snd_idle_pct = snd_pct;
		rcv_idle_pct = rcv_pct;
		span = (dly > ivl) ? int'(dly) : int'(ivl);
		span = span + span / 4 + 4;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 5) begin
				// noise: jump anywhere in time with any mask
				cur_mask = bea_pkg::MASK_W'($urandom_range(255));
				cur_time = $urandom;
			end else begin
				if (r < 15)
					cur_mask = bea_pkg::MASK_W'($urandom_range(255));
				else if ($urandom_range(3) == 0)
					cur_mask[$urandom_range(NB - 1)] ^= 1'b1;
				if (r < 18)
					cur_time = cur_time - $urandom_range(span);
				else
					cur_time = cur_time + $urandom_range(span);
			end
			send_poll(cur_mask, cur_time, bea_pkg::QUERY_W'($urandom_range(NB - 1)));
		end
	endtask

	task automatic test_backpressure();
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		fork
			begin
				@(posedge clk);
				rcv_hold = 1'b1;
				repeat (300) @(posedge clk);
				rcv_hold = 1'b0;
			end
		join_none
		for (int k = 0; k < 40; k++) begin
			cur_time = cur_time + $urandom_range(60);
			if ($urandom_range(2) == 0)
				cur_mask[$urandom_range(NB - 1)] ^= 1'b1;
			send_poll(cur_mask, cur_time, bea_pkg::QUERY_W'($urandom_range(NB - 1)));
		end
		// hold the sender back until every result is in
		wait_idle();
		for (int k = 0; k < 20; k++) begin
			cur_time = cur_time + $urandom_range(40);
			send_poll(cur_mask, cur_time, bea_pkg::QUERY_W'($urandom_range(NB - 1)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		buttons_now = '0;
		time_ms = '0;
		query_button = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = bea_pkg::REG_REPEAT_DELAY;
		cfg_data = '0;
		mismatch_cnt = 0;
		cycle_cnt = 0;
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		rcv_hold = 1'b0;
		delay_ms = bea_pkg::REPEAT_DELAY_RST;
		interval_ms = bea_pkg::REPEAT_INTERVAL_RST;
		last_mask = '0;
		for (int i = 0; i < NB; i++) begin
			pressed_at[i] = '0;
			due_at[i] = '0;
		end
		cur_mask = '0;
		cur_time = $urandom;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_edges_and_repeats();
		test_time_wrap();
		snd_idle_pct = 20;
		rcv_idle_pct = 20;
		test_zero_timing();
		test_max_timing();
		test_random_polls(480, 27, 86, bea_pkg::CFG_W'($urandom_range(20, 400)),
			bea_pkg::CFG_W'($urandom_range(5, 150)));
		test_random_polls(480, 86, 27, bea_pkg::CFG_W'($urandom_range(0, 65535)),
			bea_pkg::CFG_W'($urandom_range(0, 65535)));
		test_random_polls(480, 0, 0, bea_pkg::CFG_W'($urandom_range(0, 100)),
			bea_pkg::CFG_W'($urandom_range(0, 100)));
		test_backpressure();

		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire

[filelist.f]
design/bea_pkg.sv
design/bea_lane.sv
design/bea_merge.sv
design/bea_out_buf.sv
design/button_edge_and_autorepeat.sv
dv/tb.sv
